### src/chte_pkg.sv
`default_nettype none

package chte_pkg;

  // Sizes of the node pool and of the bucket array.
  localparam int unsigned MAX_NODES   = 1024;
  localparam int unsigned MAX_BUCKETS = 2048;
  localparam int unsigned MIN_BUCKETS = 8;
  localparam int unsigned NODE_W      = $clog2(MAX_NODES);
  localparam int unsigned LINK_W      = NODE_W + 1;
  localparam int unsigned BKT_AW      = $clog2(MAX_BUCKETS);
  localparam int unsigned BT_W        = BKT_AW + 1;
  localparam int unsigned MIN_LOG     = $clog2(MIN_BUCKETS);

  localparam logic [31:0] HASH_MULT = 32'h9E37_79B1;
  localparam logic [LINK_W-1:0] NONE = LINK_W'(MAX_NODES);

  // Result status codes.
  localparam logic [1:0] STS_OK   = 2'd0;
  localparam logic [1:0] STS_MISS = 2'd1;
  localparam logic [1:0] STS_FULL = 2'd2;

  typedef enum logic [2:0] {
    OP_GET        = 3'd0,
    OP_PUT        = 3'd1,
    OP_REMOVE     = 3'd2,
    OP_ITER_FIRST = 3'd3,
    OP_ITER_NEXT  = 3'd4,
    OP_CLEAR      = 3'd5
  } op_t;

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_HEAD, S_NODE, S_ALLOC, S_INS, S_GHEAD, S_GNODE,
    S_GWA, S_GWB, S_ITL, S_SCAN, S_SCANR, S_IKEY, S_DONE
  } state_t;

  // Low bits of the Fibonacci hash; only they survive the bucket mask.
  function automatic logic [BKT_AW-1:0] hash_of(input logic [31:0] key);
    logic [2*BKT_AW-1:0] prod;
    prod = {{BKT_AW{1'b0}}, key[BKT_AW-1:0]} * {{BKT_AW{1'b0}}, HASH_MULT[BKT_AW-1:0]};
    return prod[BKT_AW-1:0];
  endfunction

  // Smallest power of two at or above the request, clamped to the legal range.
  function automatic logic [BT_W-1:0] round_buckets(input logic [BT_W-1:0] req);
    logic [BT_W-1:0] p;
    p = BT_W'(MAX_BUCKETS);
    for (int k = BKT_AW; k >= MIN_LOG; k--) begin
      if (req <= (BT_W'(1) << k)) begin
        p = BT_W'(1) << k;
      end
    end
    return p;
  endfunction

endpackage

`default_nettype wire

### src/chte_ram.sv
`default_nettype none

module chte_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

### src/chained_hash_table_engine_top.sv
`default_nettype none
// Get, put and remove read the bucket head, then compare one chain node at a time; a put
//   that misses may first grow the table, relinking each old bucket's nodes, then inserts.
// Iteration scans the buckets in order and follows the links within a chain.
// One item is in work at a time; the next is taken in the cycle after its result is
//   registered, so the throughput is set by the chain walk.
// Reset, a bucket count write and clear empty all 2048 bucket heads; no item is taken.

module chained_hash_table_engine_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output      logic        in_ready,
  input  wire logic [2:0]  in_operation,
  input  wire logic [31:0] in_key,
  output      logic        out_valid,
  input  wire logic        out_ready,
  output      logic [1:0]  out_status,
  output      logic [9:0]  out_handle,
  output      logic        out_created,
  output      logic [31:0] out_key_out,
  output      logic [10:0] out_entry_count,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output      logic [31:0] prdata,
  output      logic        pready
);

  localparam int unsigned NW = chte_pkg::NODE_W;
  localparam int unsigned LW = chte_pkg::LINK_W;
  localparam int unsigned AW = chte_pkg::BKT_AW;
  localparam int unsigned BW = chte_pkg::BT_W;

  chte_pkg::state_t state_r, state_nxt;
  chte_pkg::op_t    op_r, op_nxt;
  logic [31:0]   key_r, key_nxt;
  logic [AW-1:0] hash_r, hash_nxt;
  logic [LW-1:0] cur_r, cur_nxt, prev_r, prev_nxt;
  logic [LW-1:0] ha_r, ha_nxt, hb_r, hb_nxt;
  logic [BW-1:0] bt_r, bt_nxt, idx_r, idx_nxt, iter_bucket_r, iter_bucket_nxt;
  logic [BW-1:0] init_r, init_nxt;
  logic [LW-1:0] cnt_r, cnt_nxt, top_r, top_nxt, mintop_r, mintop_nxt;
  logic [LW-1:0] iter_node_r, iter_node_nxt;
  logic [NW-1:0] pop_idx_r, pop_idx_nxt;
  logic          fresh_r, fresh_nxt, clr_res_r, clr_res_nxt;
  logic [1:0]    res_status_r, res_status_nxt;
  logic [NW-1:0] res_handle_r, res_handle_nxt;
  logic          res_created_r, res_created_nxt;
  logic [31:0]   res_key_r, res_key_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [1:0]    out_status_r, out_status_nxt;
  logic [NW-1:0] out_handle_r, out_handle_nxt;
  logic          out_created_r, out_created_nxt;
  logic [31:0]   out_key_r, out_key_nxt;
  logic [LW-1:0] out_cnt_r, out_cnt_nxt;

  // Memory ports.
  logic          head_we, key_we, link_we, free_we;
  logic [AW-1:0] head_wa, head_ra;
  logic [LW-1:0] head_wd, head_rd;
  logic [NW-1:0] key_wa, key_ra, link_wa, link_ra, free_wa, free_ra;
  logic [31:0]   key_wd, key_rd;
  logic [LW-1:0] link_wd, link_rd;
  logic [NW-1:0] free_wd, free_rd;

  logic          cfg_wr;
  logic [AW-1:0] mask, slot;
  logic          grow_due, upper;
  logic [NW-1:0] new_node;

  chte_ram #(.WIDTH(LW), .DEPTH(chte_pkg::MAX_BUCKETS)) u_head (
    .clk(clk), .we(head_we), .waddr(head_wa), .wdata(head_wd), .raddr(head_ra),
    .rdata(head_rd));
  chte_ram #(.WIDTH(32), .DEPTH(chte_pkg::MAX_NODES)) u_key (
    .clk(clk), .we(key_we), .waddr(key_wa), .wdata(key_wd), .raddr(key_ra),
    .rdata(key_rd));
  chte_ram #(.WIDTH(LW), .DEPTH(chte_pkg::MAX_NODES)) u_link (
    .clk(clk), .we(link_we), .waddr(link_wa), .wdata(link_wd), .raddr(link_ra),
    .rdata(link_rd));
  chte_ram #(.WIDTH(NW), .DEPTH(chte_pkg::MAX_NODES)) u_free (
    .clk(clk), .we(free_we), .waddr(free_wa), .wdata(free_wd), .raddr(free_ra),
    .rdata(free_rd));

  // Register port: one register, decoded at addresses 0 to 3.
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & (paddr[2] == 1'b0);
  assign prdata = (paddr[2] == 1'b0) ? {{(32 - BW){1'b0}}, init_r} : 32'd0;

  assign in_ready        = (state_r == chte_pkg::S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_handle      = out_handle_r;
  assign out_created     = out_created_r;
  assign out_key_out     = out_key_r;
  assign out_entry_count = out_cnt_r;

  assign mask     = AW'(bt_r - BW'(1));
  assign slot     = hash_r & mask;
  assign grow_due = ({1'b0, cnt_r + LW'(1), 2'b00} > (14'(bt_r) * 14'd3)) &&
                    (bt_r < BW'(chte_pkg::MAX_BUCKETS));
  assign upper    = (chte_pkg::hash_of(key_rd) & bt_r[AW-1:0]) != '0;
  assign new_node = fresh_r ? (NW'(chte_pkg::MAX_NODES - 1) - pop_idx_r) : free_rd;

  // Next state, memory accesses and result assembly.
  always_comb begin
    logic hit, miss;
    hit = 1'b0;
    miss = 1'b0;
    state_nxt = state_r;
    op_nxt = op_r;
    key_nxt = key_r;
    hash_nxt = hash_r;
    cur_nxt = cur_r;
    prev_nxt = prev_r;
    ha_nxt = ha_r;
    hb_nxt = hb_r;
    bt_nxt = bt_r;
    idx_nxt = idx_r;
    iter_bucket_nxt = iter_bucket_r;
    iter_node_nxt = iter_node_r;
    init_nxt = init_r;
    cnt_nxt = cnt_r;
    top_nxt = top_r;
    mintop_nxt = mintop_r;
    pop_idx_nxt = pop_idx_r;
    fresh_nxt = fresh_r;
    clr_res_nxt = clr_res_r;
    res_status_nxt = res_status_r;
    res_handle_nxt = res_handle_r;
    res_created_nxt = res_created_r;
    res_key_nxt = res_key_r;
    out_valid_nxt = out_valid_r & ~out_ready;
    out_status_nxt = out_status_r;
    out_handle_nxt = out_handle_r;
    out_created_nxt = out_created_r;
    out_key_nxt = out_key_r;
    out_cnt_nxt = out_cnt_r;
    head_we = 1'b0;
    head_wa = slot;
    head_wd = chte_pkg::NONE;
    head_ra = slot;
    key_we = 1'b0;
    key_wa = new_node;
    key_wd = key_r;
    key_ra = cur_r[NW-1:0];
    link_we = 1'b0;
    link_wa = cur_r[NW-1:0];
    link_wd = link_rd;
    link_ra = cur_r[NW-1:0];
    free_we = 1'b0;
    free_wa = top_r[NW-1:0];
    free_wd = cur_r[NW-1:0];
    free_ra = pop_idx_r;

    unique case (state_r)
      chte_pkg::S_CLR: begin
        head_we = 1'b1;
        head_wa = idx_r[AW-1:0];
        if (idx_r == BW'(chte_pkg::MAX_BUCKETS - 1)) begin
          idx_nxt = '0;
          state_nxt = clr_res_r ? chte_pkg::S_DONE : chte_pkg::S_IDLE;
        end else begin
          idx_nxt = idx_r + BW'(1);
        end
      end
      chte_pkg::S_IDLE: begin
        if (in_valid) begin
          op_nxt = chte_pkg::op_t'(in_operation);
          key_nxt = in_key;
          hash_nxt = chte_pkg::hash_of(in_key);
          prev_nxt = chte_pkg::NONE;
          res_status_nxt = chte_pkg::STS_MISS;
          res_handle_nxt = '0;
          res_created_nxt = 1'b0;
          res_key_nxt = '0;
          head_ra = chte_pkg::hash_of(in_key) & mask;
          case (in_operation)
            chte_pkg::OP_GET, chte_pkg::OP_PUT, chte_pkg::OP_REMOVE: begin
              state_nxt = chte_pkg::S_HEAD;
            end
            chte_pkg::OP_ITER_FIRST: begin
              iter_bucket_nxt = '0;
              iter_node_nxt = chte_pkg::NONE;
              idx_nxt = '0;
              state_nxt = chte_pkg::S_SCAN;
            end
            chte_pkg::OP_ITER_NEXT: begin
              if (!iter_node_r[NW]) begin
                link_ra = iter_node_r[NW-1:0];
                state_nxt = chte_pkg::S_ITL;
              end else begin
                idx_nxt = iter_bucket_r;
                state_nxt = chte_pkg::S_SCAN;
              end
            end
            chte_pkg::OP_CLEAR: begin
              cnt_nxt = '0;
              top_nxt = LW'(chte_pkg::MAX_NODES);
              mintop_nxt = LW'(chte_pkg::MAX_NODES);
              iter_bucket_nxt = '0;
              iter_node_nxt = chte_pkg::NONE;
              bt_nxt = chte_pkg::round_buckets(init_r);
              idx_nxt = '0;
              clr_res_nxt = 1'b1;
              res_status_nxt = chte_pkg::STS_OK;
              state_nxt = chte_pkg::S_CLR;
            end
            default: begin
              state_nxt = chte_pkg::S_DONE;
            end
          endcase
        end
      end
      chte_pkg::S_HEAD: begin
        cur_nxt = head_rd;
        key_ra = head_rd[NW-1:0];
        link_ra = head_rd[NW-1:0];
        if (head_rd[NW]) begin
          miss = 1'b1;
        end else begin
          state_nxt = chte_pkg::S_NODE;
        end
      end
      chte_pkg::S_NODE: begin
        if (key_rd == key_r) begin
          hit = 1'b1;
        end else begin
          prev_nxt = cur_r;
          cur_nxt = link_rd;
          key_ra = link_rd[NW-1:0];
          link_ra = link_rd[NW-1:0];
          miss = link_rd[NW];
        end
      end
      chte_pkg::S_ALLOC: begin
        if (top_r == '0) begin
          res_status_nxt = chte_pkg::STS_FULL;
          state_nxt = chte_pkg::S_DONE;
        end else begin
          top_nxt = top_r - LW'(1);
          pop_idx_nxt = NW'(top_r - LW'(1));
          free_ra = NW'(top_r - LW'(1));
          fresh_nxt = (top_r - LW'(1)) < mintop_r;
          if ((top_r - LW'(1)) < mintop_r) begin
            mintop_nxt = top_r - LW'(1);
          end
          state_nxt = chte_pkg::S_INS;
        end
      end
      chte_pkg::S_INS: begin
        // Push the new node on the head of its chain.
        key_we = 1'b1;
        link_we = 1'b1;
        link_wa = new_node;
        link_wd = head_rd;
        head_we = 1'b1;
        head_wd = {1'b0, new_node};
        cnt_nxt = cnt_r + LW'(1);
        res_status_nxt = chte_pkg::STS_OK;
        res_handle_nxt = new_node;
        res_created_nxt = 1'b1;
        state_nxt = chte_pkg::S_DONE;
      end
      chte_pkg::S_GHEAD: begin
        cur_nxt = head_rd;
        key_ra = head_rd[NW-1:0];
        link_ra = head_rd[NW-1:0];
        state_nxt = head_rd[NW] ? chte_pkg::S_GWA : chte_pkg::S_GNODE;
      end
      chte_pkg::S_GNODE: begin
        // Relink the node onto the lower or the upper half of the split bucket.
        link_we = 1'b1;
        link_wd = upper ? hb_r : ha_r;
        if (upper) begin
          hb_nxt = cur_r;
        end else begin
          ha_nxt = cur_r;
        end
        cur_nxt = link_rd;
        key_ra = link_rd[NW-1:0];
        link_ra = link_rd[NW-1:0];
        if (link_rd[NW]) begin
          state_nxt = chte_pkg::S_GWA;
        end
      end
      chte_pkg::S_GWA: begin
        head_we = 1'b1;
        head_wa = idx_r[AW-1:0];
        head_wd = ha_r;
        state_nxt = chte_pkg::S_GWB;
      end
      chte_pkg::S_GWB: begin
        head_we = 1'b1;
        head_wa = AW'(idx_r + bt_r);
        head_wd = hb_r;
        ha_nxt = chte_pkg::NONE;
        hb_nxt = chte_pkg::NONE;
        head_ra = AW'(idx_r + BW'(1));
        if ((idx_r + BW'(1)) == bt_r) begin
          bt_nxt = bt_r << 1;
          state_nxt = chte_pkg::S_ALLOC;
        end else begin
          idx_nxt = idx_r + BW'(1);
          state_nxt = chte_pkg::S_GHEAD;
        end
      end
      chte_pkg::S_ITL: begin
        if (link_rd[NW]) begin
          idx_nxt = iter_bucket_r;
          state_nxt = chte_pkg::S_SCAN;
        end else begin
          cur_nxt = link_rd;
          iter_node_nxt = link_rd;
          key_ra = link_rd[NW-1:0];
          state_nxt = chte_pkg::S_IKEY;
        end
      end
      chte_pkg::S_SCAN: begin
        head_ra = idx_r[AW-1:0];
        if (idx_r < bt_r) begin
          idx_nxt = idx_r + BW'(1);
          state_nxt = chte_pkg::S_SCANR;
        end else begin
          iter_node_nxt = chte_pkg::NONE;
          res_status_nxt = chte_pkg::STS_MISS;
          state_nxt = chte_pkg::S_DONE;
        end
      end
      chte_pkg::S_SCANR: begin
        if (head_rd[NW]) begin
          state_nxt = chte_pkg::S_SCAN;
        end else begin
          iter_bucket_nxt = idx_r;
          iter_node_nxt = head_rd;
          cur_nxt = head_rd;
          key_ra = head_rd[NW-1:0];
          state_nxt = chte_pkg::S_IKEY;
        end
      end
      chte_pkg::S_IKEY: begin
        res_status_nxt = chte_pkg::STS_OK;
        res_handle_nxt = cur_r[NW-1:0];
        res_key_nxt = key_rd;
        state_nxt = chte_pkg::S_DONE;
      end
      chte_pkg::S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_status_nxt = res_status_r;
          out_handle_nxt = res_handle_r;
          out_created_nxt = res_created_r;
          out_key_nxt = res_key_r;
          out_cnt_nxt = cnt_r;
          clr_res_nxt = 1'b0;
          state_nxt = chte_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = chte_pkg::S_IDLE;
      end
    endcase

    // Key found in its chain.
    if (hit) begin
      res_status_nxt = chte_pkg::STS_OK;
      res_handle_nxt = cur_r[NW-1:0];
      state_nxt = chte_pkg::S_DONE;
      if (op_r == chte_pkg::OP_REMOVE) begin
        if (prev_r[NW]) begin
          head_we = 1'b1;
        end else begin
          link_we = 1'b1;
          link_wa = prev_r[NW-1:0];
        end
        head_wd = link_rd;
        if (top_r < LW'(chte_pkg::MAX_NODES)) begin
          free_we = 1'b1;
          top_nxt = top_r + LW'(1);
        end
        if (cnt_r != '0) begin
          cnt_nxt = cnt_r - LW'(1);
        end
      end
    end

    // Chain ended without the key.
    if (miss) begin
      state_nxt = chte_pkg::S_DONE;
      if (op_r == chte_pkg::OP_PUT) begin
        if (grow_due) begin
          idx_nxt = '0;
          ha_nxt = chte_pkg::NONE;
          hb_nxt = chte_pkg::NONE;
          head_ra = '0;
          state_nxt = chte_pkg::S_GHEAD;
        end else begin
          state_nxt = chte_pkg::S_ALLOC;
        end
      end
    end

    // A register write empties the table and applies the new bucket count.
    if (cfg_wr) begin
      init_nxt = pwdata[BW-1:0];
      cnt_nxt = '0;
      top_nxt = LW'(chte_pkg::MAX_NODES);
      mintop_nxt = LW'(chte_pkg::MAX_NODES);
      iter_bucket_nxt = '0;
      iter_node_nxt = chte_pkg::NONE;
      bt_nxt = chte_pkg::round_buckets(pwdata[BW-1:0]);
      idx_nxt = '0;
      clr_res_nxt = 1'b0;
      state_nxt = chte_pkg::S_CLR;
    end
  end

  // State register with control state cleared on reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= chte_pkg::S_CLR;
      init_r <= BW'(chte_pkg::MIN_BUCKETS);
      bt_r <= BW'(chte_pkg::MIN_BUCKETS);
      idx_r <= '0;
      cnt_r <= '0;
      top_r <= LW'(chte_pkg::MAX_NODES);
      mintop_r <= LW'(chte_pkg::MAX_NODES);
      iter_bucket_r <= '0;
      iter_node_r <= chte_pkg::NONE;
      clr_res_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      init_r <= init_nxt;
      bt_r <= bt_nxt;
      idx_r <= idx_nxt;
      cnt_r <= cnt_nxt;
      top_r <= top_nxt;
      mintop_r <= mintop_nxt;
      iter_bucket_r <= iter_bucket_nxt;
      iter_node_r <= iter_node_nxt;
      clr_res_r <= clr_res_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    op_r <= op_nxt;
    key_r <= key_nxt;
    hash_r <= hash_nxt;
    cur_r <= cur_nxt;
    prev_r <= prev_nxt;
    ha_r <= ha_nxt;
    hb_r <= hb_nxt;
    pop_idx_r <= pop_idx_nxt;
    fresh_r <= fresh_nxt;
    res_status_r <= res_status_nxt;
    res_handle_r <= res_handle_nxt;
    res_created_r <= res_created_nxt;
    res_key_r <= res_key_nxt;
    out_status_r <= out_status_nxt;
    out_handle_r <= out_handle_nxt;
    out_created_r <= out_created_nxt;
    out_key_r <= out_key_nxt;
    out_cnt_r <= out_cnt_nxt;
  end

  // Every node is either stored or on the free stack whenever the block is idle.
  a_pool_balance: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == chte_pkg::S_IDLE) |-> ((cnt_r + top_r) == LW'(chte_pkg::MAX_NODES)))
    else $error("node count and free stack disagree");

  // The bucket count stays a power of two within range.
  a_bt_pow2: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(bt_r) && (bt_r >= BW'(chte_pkg::MIN_BUCKETS)))
    else $error("bucket count is not a legal power of two");

  // The low-water mark of the free stack never lies above its top.
  a_mintop: assert property (@(posedge clk) disable iff (!rst_n)
    (mintop_r <= top_r) && (top_r <= LW'(chte_pkg::MAX_NODES)))
    else $error("free stack marks out of order");

  // An accepted transfer leaves the idle state.
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second item taken while one is in work");

endmodule

`default_nettype wire

### bench/chte_checker.sv
`timescale 1ns / 100ps

module chte_checker (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  input  wire logic        in_ready,
  input  wire logic [2:0]  in_operation,
  input  wire logic [31:0] in_key,
  input  wire logic        out_valid,
  input  wire logic        out_ready,
  input  wire logic [1:0]  out_status,
  input  wire logic [9:0]  out_handle,
  input  wire logic        out_created,
  input  wire logic [31:0] out_key_out,
  input  wire logic [10:0] out_entry_count,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  input  wire logic        pready,
  output int               pending,
  output int               fails
);

  localparam int MAX_NODES   = chte_pkg::MAX_NODES;
  localparam int MAX_BUCKETS = chte_pkg::MAX_BUCKETS;
  localparam int MIN_BUCKETS = chte_pkg::MIN_BUCKETS;
  localparam int NIL = MAX_NODES;

  typedef struct {
    logic [1:0]  status;
    logic [9:0]  handle;
    logic        created;
    logic [31:0] key_out;
    logic [10:0] entry_count;
  } lookup_res_t;

  // Shadow copy of the table.
  int heads [MAX_BUCKETS];
  int spare_heads [MAX_BUCKETS];
  logic [31:0] keys [MAX_NODES];
  int links [MAX_NODES];
  int free_list [MAX_NODES];
  int free_depth;
  int bucket_cnt;
  int entries;
  int cur_bucket;
  int cur_node;
  logic [11:0] req_buckets;

  lookup_res_t answers[$];

  function automatic int bucket_of(logic [31:0] k, int nb);
    logic [31:0] p;
    p = k * 32'd2654435761;
    return int'(p) & (nb - 1);
  endfunction

  function automatic int round_up(logic [11:0] req);
    int p;
    p = MIN_BUCKETS;
    while (p < int'(req) && p < MAX_BUCKETS) p = p << 1;
    return p;
  endfunction

  function automatic void wipe_table();
    for (int i = 0; i < MAX_BUCKETS; i++) heads[i] = NIL;
    for (int i = 0; i < MAX_NODES; i++) free_list[i] = MAX_NODES - 1 - i;
    free_depth = MAX_NODES;
    entries = 0;
    cur_bucket = 0;
    cur_node = NIL;
    bucket_cnt = round_up(req_buckets);
  endfunction

  function automatic int lookup(logic [31:0] k);
    int n;
    int steps;
    n = heads[bucket_of(k, bucket_cnt)];
    steps = 0;
    while (n < NIL && steps < MAX_NODES) begin
      if (keys[n] == k) return n;
      n = links[n];
      steps++;
    end
    return NIL;
  endfunction

  // Doubling: old buckets in order, each chain from its head, head insertion.
  function automatic void double_table();
    int nb;
    int n;
    int nx;
    int j;
    int steps;
    nb = bucket_cnt << 1;
    for (int i = 0; i < nb; i++) spare_heads[i] = NIL;
    for (int i = 0; i < bucket_cnt; i++) begin
      n = heads[i];
      steps = 0;
      while (n < NIL && steps < MAX_NODES) begin
        nx = links[n];
        j = bucket_of(keys[n], nb);
        links[n] = spare_heads[j];
        spare_heads[j] = n;
        n = nx;
        steps++;
      end
    end
    for (int i = 0; i < nb; i++) heads[i] = spare_heads[i];
    bucket_cnt = nb;
  endfunction

  function automatic void walk_on(ref lookup_res_t r);
    int n;
    int b;
    n = (cur_node < NIL) ? links[cur_node] : NIL;
    b = cur_bucket;
    if (n > NIL) n = NIL;
    while (n == NIL && b < bucket_cnt && b < MAX_BUCKETS) begin
      n = heads[b];
      b++;
    end
    if (n >= NIL) begin
      cur_node = NIL;
      r.status = chte_pkg::STS_MISS;
      return;
    end
    cur_bucket = b;
    cur_node = n;
    r.status = chte_pkg::STS_OK;
    r.handle = n[9:0];
    r.key_out = keys[n];
  endfunction

  function automatic lookup_res_t apply_op(logic [2:0] op, logic [31:0] k);
    lookup_res_t r;
    int n;
    int idx;
    int prev;
    int steps;
    r = '{chte_pkg::STS_MISS, '0, 1'b0, '0, '0};
    case (op)
      chte_pkg::OP_GET: begin
        n = lookup(k);
        if (n < NIL) begin
          r.status = chte_pkg::STS_OK;
          r.handle = n[9:0];
        end
      end
      chte_pkg::OP_PUT: begin
        n = lookup(k);
        if (n < NIL) begin
          r.status = chte_pkg::STS_OK;
          r.handle = n[9:0];
        end else begin
          if ((entries + 1) * 4 > bucket_cnt * 3 && (bucket_cnt << 1) <= MAX_BUCKETS)
            double_table();
          if (free_depth == 0) begin
            r.status = chte_pkg::STS_FULL;
          end else begin
            free_depth--;
            n = free_list[free_depth];
            idx = bucket_of(k, bucket_cnt);
            keys[n] = k;
            links[n] = heads[idx];
            heads[idx] = n;
            entries++;
            r.status = chte_pkg::STS_OK;
            r.handle = n[9:0];
            r.created = 1'b1;
          end
        end
      end
      chte_pkg::OP_REMOVE: begin
        idx = bucket_of(k, bucket_cnt);
        prev = NIL;
        steps = 0;
        n = heads[idx];
        while (n < NIL && steps < MAX_NODES) begin
          if (keys[n] == k) begin
            if (prev < NIL) links[prev] = links[n];
            else heads[idx] = links[n];
            if (free_depth < MAX_NODES) begin
              free_list[free_depth] = n;
              free_depth++;
            end
            if (entries > 0) entries--;
            r.status = chte_pkg::STS_OK;
            r.handle = n[9:0];
            break;
          end
          prev = n;
          n = links[n];
          steps++;
        end
      end
      chte_pkg::OP_ITER_FIRST: begin
        cur_bucket = 0;
        cur_node = NIL;
        walk_on(r);
      end
      chte_pkg::OP_ITER_NEXT: walk_on(r);
      chte_pkg::OP_CLEAR: begin
        wipe_table();
        r.status = chte_pkg::STS_OK;
      end
      default: ;
    endcase
    r.entry_count = entries[10:0];
    return r;
  endfunction

  // Result transfers are checked before the input transfer of the same edge is predicted.
  always @(posedge clk) begin
    lookup_res_t e;
    if (!rst_n) begin
      req_buckets = 12'd8;
      wipe_table();
      answers.delete();
      fails <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (answers.size() == 0) begin
          $error("result transfer with nothing outstanding");
          fails <= fails + 1;
        end else begin
          e = answers.pop_front();
          if (out_status !== e.status || out_handle !== e.handle ||
              out_created !== e.created || out_key_out !== e.key_out ||
              out_entry_count !== e.entry_count) begin
            fails <= fails + 1;
            if (out_status !== e.status)
              $error("status: expected %0d, got %0d", e.status, out_status);
            if (out_handle !== e.handle)
              $error("handle: expected %0d, got %0d", e.handle, out_handle);
            if (out_created !== e.created)
              $error("created: expected %0d, got %0d", e.created, out_created);
            if (out_key_out !== e.key_out)
              $error("key_out: expected %h, got %h", e.key_out, out_key_out);
            if (out_entry_count !== e.entry_count)
              $error("entry_count: expected %0d, got %0d", e.entry_count,
                     out_entry_count);
          end
        end
      end
      if (psel && penable && pwrite && pready && paddr == 3'd0) begin
        req_buckets = pwdata[11:0];
        wipe_table();
      end
      if (in_valid && in_ready) answers.push_back(apply_op(in_operation, in_key));
    end
    pending <= answers.size();
  end

endmodule

### bench/tb.sv
`timescale 1ns / 100ps

module tb;

  localparam logic [2:0] OP_UNUSED_A = 3'd6;
  localparam logic [2:0] OP_UNUSED_B = 3'd7;
  localparam logic [2:0] REG_INIT_BUCKETS = 3'd0;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [2:0]  in_operation = '0;
  logic [31:0] in_key = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  out_status;
  logic [9:0]  out_handle;
  logic        out_created;
  logic [31:0] out_key_out;
  logic [10:0] out_entry_count;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  int          pending;
  int          fails;
  bit          calm = 1'b0;
  int          stall_left = 0;
  logic [31:0] key_pool [48];

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  chained_hash_table_engine_top dut (.*);

  chte_checker checker_i (.*);

  // The receiver stalls in random bursts, and not at all in the calm part.
  always @(posedge clk) begin
    if (calm) begin
      out_ready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 1'b0;
    end else if ($urandom_range(0, 4) == 0) begin
      stall_left <= $urandom_range(0, 10);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // One input transfer, sometimes after a burst of idle cycles.
  task automatic send(logic [2:0] op, logic [31:0] k);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_operation <= op;
    in_key <= k;
    do @(posedge clk); while (!in_ready);
  endtask

  // Waits for every outstanding result, then idles for settle clocks so a clearing pass can finish.
  task automatic drain(int settle);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic write_buckets(logic [31:0] v);
    drain(2200);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= REG_INIT_BUCKETS;
    pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    for (int i = 0; i < 48; i++) key_pool[i] = $urandom();
  endtask

  // Mostly keys from a small pool so that gets and removes hit.
  function automatic logic [31:0] pick_key();
    return ($urandom_range(0, 9) == 0) ? $urandom() : key_pool[$urandom_range(0, 47)];
  endfunction

  task automatic random_items(int count);
    int w;
    for (int i = 0; i < count; i++) begin
      w = $urandom_range(0, 99);
      if (w < 35) send(chte_pkg::OP_PUT, pick_key());
      else if (w < 58) send(chte_pkg::OP_GET, pick_key());
      else if (w < 78) send(chte_pkg::OP_REMOVE, pick_key());
      else if (w < 84) send(chte_pkg::OP_ITER_FIRST, $urandom());
      else if (w < 95) send(chte_pkg::OP_ITER_NEXT, $urandom());
      else if (w < 97) send(chte_pkg::OP_CLEAR, $urandom());
      else send($urandom_range(0, 1) ? OP_UNUSED_A : OP_UNUSED_B, $urandom());
      // A clear starts a clearing pass; wait for it to finish before the next item.
      if (w >= 95 && w < 97) drain(2200);
    end
  endtask

  initial begin
    #3_000_000;
    $display("tb NOT OK");
    $finish;
  end

  initial begin
    for (int i = 0; i < 48; i++) key_pool[i] = $urandom();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty table, extreme keys, hits, misses and iteration edges.
    send(chte_pkg::OP_ITER_NEXT, 32'h0);
    send(chte_pkg::OP_GET, 32'h0);
    send(chte_pkg::OP_PUT, 32'h0);
    send(chte_pkg::OP_PUT, 32'hFFFF_FFFF);
    send(chte_pkg::OP_PUT, 32'hFFFF_FFFF);
    send(chte_pkg::OP_GET, 32'hFFFF_FFFF);
    send(chte_pkg::OP_REMOVE, 32'h1234_5678);
    send(chte_pkg::OP_PUT, 32'h8000_0001);
    send(chte_pkg::OP_ITER_FIRST, 32'h0);
    send(chte_pkg::OP_REMOVE, 32'h0);
    send(chte_pkg::OP_ITER_NEXT, 32'h0);
    send(chte_pkg::OP_ITER_NEXT, 32'h0);
    send(chte_pkg::OP_ITER_NEXT, 32'h0);
    send(chte_pkg::OP_ITER_NEXT, 32'h0);
    send(OP_UNUSED_A, 32'hFFFF_FFFF);
    send(OP_UNUSED_B, 32'h0);
    send(chte_pkg::OP_REMOVE, 32'hFFFF_FFFF);
    send(chte_pkg::OP_GET, 32'hFFFF_FFFF);
    send(chte_pkg::OP_CLEAR, 32'h0);
    drain(2200);
    send(chte_pkg::OP_ITER_NEXT, 32'h0);

    write_buckets(32'd0);
    random_items(120);
    // Hold the sender until everything has come back.
    drain(0);
    random_items(40);

    write_buckets(32'd4095);
    random_items(60);

    // Fill the table through the growth steps up to 1024 buckets.
    write_buckets(32'd1);
    for (int i = 0; i < 400; i++) begin
      send(chte_pkg::OP_PUT, 32'(i) * 32'h0101_0101 + 32'h5A5A_0000);
      if (i % 128 == 0) send(chte_pkg::OP_ITER_NEXT, 32'h0);
    end
    random_items(30);

    write_buckets(32'd2048);
    random_items(50);

    write_buckets(32'd100);
    random_items(50);
    drain(0);
    calm = 1'b1;
    random_items(100);

    drain(200);
    if (fails == 0 && pending == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
